// File: src/rlps_pkg.sv
// ----------------------------------------------------------------------------
// RGB LED pattern sequencer package
// Shared widths, event codes and pattern codes.
// ----------------------------------------------------------------------------
package rlps_pkg;

  localparam int LEVEL_W       = 8;
  localparam int LEVEL_MAX_DEF = 255;
  localparam int HOLD_W        = 16;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_DATA_W     = 8;
  localparam int OUT_DATA_W    = 32;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  localparam logic [1:0] PAT_ALL_FADE = 2'd0;
  localparam logic [1:0] PAT_SEQ_RISE = 2'd1;
  localparam logic [1:0] PAT_SEQ_FADE = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LIMIT = 1'd1;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef struct packed {
    level_t     red;
    level_t     green;
    level_t     blue;
    logic [1:0] pattern;
  } lamp_t;

endpackage

// File: src/rlps_press_classifier.sv
// ----------------------------------------------------------------------------
// Press classifier
// Debounces the button and reports a short or long press on release.
// ----------------------------------------------------------------------------
module rlps_press_classifier
  import rlps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              pressed,
  input  logic [HOLD_W-1:0] debounce_ticks,
  input  logic [HOLD_W-1:0] short_limit_ticks,
  output logic [1:0]        press_event
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_BOUNCE = 2'd1;
  localparam logic [1:0] PH_SHORT  = 2'd2;
  localparam logic [1:0] PH_LONG   = 2'd3;

  logic [1:0]        phase;
  logic [1:0]        phase_next;
  logic [HOLD_W-1:0] hold_count;
  logic [HOLD_W-1:0] hold_count_next;
  logic [HOLD_W-1:0] hold_inc;

  assign hold_inc = (hold_count != {HOLD_W{1'b1}}) ? hold_count + 1'b1 : hold_count;

  always_comb begin
    phase_next      = phase;
    hold_count_next = hold_count;
    press_event     = EV_NONE;
    case (phase)
      PH_IDLE: begin
        if (pressed) begin
          phase_next      = PH_BOUNCE;
          hold_count_next = '0;
        end
      end
      PH_BOUNCE: begin
        if (!pressed) begin
          phase_next = PH_IDLE;
        end else begin
          if (hold_count >= debounce_ticks) phase_next = PH_SHORT;
          hold_count_next = hold_inc;
        end
      end
      PH_SHORT: begin
        if (!pressed) begin
          phase_next  = PH_IDLE;
          press_event = EV_SHORT;
        end else begin
          if (hold_count >= short_limit_ticks) phase_next = PH_LONG;
          hold_count_next = hold_inc;
        end
      end
      default: begin
        if (!pressed) begin
          phase_next  = PH_IDLE;
          press_event = EV_LONG;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hold_count <= '0;
    end else if (step) begin
      phase      <= phase_next;
      hold_count <= hold_count_next;
    end
  end

endmodule

// File: src/rlps_pattern_engine.sv
// ----------------------------------------------------------------------------
// Pattern engine
// Holds the pattern state and works out the colour levels for each tick.
// ----------------------------------------------------------------------------
module rlps_pattern_engine
  import rlps_pkg::*;
#(
  parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [1:0] press_event,
  output lamp_t      lamp_next
);

  localparam level_t LMAX = LEVEL_W'(LEVEL_MAX);

  logic [1:0] pattern_sel;
  logic [2:0] ramp_phase;
  level_t     ramp_count;
  level_t     levels [3];
  logic [1:0] tick_divider;

  logic [1:0] sel_next;
  logic [2:0] phase_next;
  level_t     count_next;
  level_t     levels_next [3];
  logic [1:0] div_next;

  always_comb begin
    logic [1:0] c;
    sel_next    = (pattern_sel == 2'd3) ? PAT_ALL_FADE : pattern_sel;
    phase_next  = ramp_phase;
    count_next  = ramp_count;
    levels_next = levels;
    div_next    = tick_divider;
    c           = 2'd0;

    if (press_event == EV_SHORT) begin
      sel_next    = (sel_next == PAT_SEQ_FADE) ? PAT_ALL_FADE : sel_next + 2'd1;
      levels_next = '{default: '0};
      count_next  = '0;
      div_next    = '0;
      phase_next  = '0;
    end

    if (sel_next == PAT_SEQ_RISE) begin
      if (div_next != 2'd0) begin
        div_next = div_next + 2'd1;
      end else begin
        if (phase_next > 3'd2) phase_next = 3'd0;
        c = phase_next[1:0];
        if (count_next < LMAX) begin
          count_next     = count_next + 1'b1;
          levels_next[c] = levels_next[c] + 1'b1;
        end else begin
          phase_next     = (c == 2'd2) ? 3'd0 : {1'b0, c + 2'd1};
          count_next     = '0;
          levels_next[c] = '0;
        end
        div_next = 2'd1;
      end
    end else begin
      if (div_next == 2'd1) begin
        div_next = 2'd0;
      end else begin
        if (sel_next == PAT_ALL_FADE) begin
          if (phase_next > 3'd1) phase_next = 3'd0;
          if (phase_next == 3'd0) begin
            if (count_next < LMAX) begin
              count_next  = count_next + 1'b1;
              for (int i = 0; i < 3; i++) levels_next[i] = levels_next[i] + 1'b1;
            end else begin
              phase_next = 3'd1;
            end
          end else begin
            if (count_next != '0) begin
              count_next  = count_next - 1'b1;
              for (int i = 0; i < 3; i++) levels_next[i] = levels_next[i] - 1'b1;
            end else begin
              phase_next = 3'd0;
            end
          end
        end else begin
          if (phase_next > 3'd5) phase_next = 3'd0;
          c = phase_next[2:1];
          if (!phase_next[0]) begin
            if (count_next < LMAX) begin
              count_next     = count_next + 1'b1;
              levels_next[c] = levels_next[c] + 1'b1;
            end else begin
              phase_next = phase_next + 3'd1;
            end
          end else begin
            if (count_next != '0) begin
              count_next     = count_next - 1'b1;
              levels_next[c] = levels_next[c] - 1'b1;
            end else begin
              phase_next = (phase_next == 3'd5) ? 3'd0 : phase_next + 3'd1;
            end
          end
        end
        div_next = div_next + 2'd1;
      end
    end
  end

  assign lamp_next.red     = levels_next[0];
  assign lamp_next.green   = levels_next[1];
  assign lamp_next.blue    = levels_next[2];
  assign lamp_next.pattern = sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_sel  <= PAT_ALL_FADE;
      ramp_phase   <= '0;
      ramp_count   <= '0;
      levels       <= '{default: '0};
      tick_divider <= '0;
    end else if (step) begin
      pattern_sel  <= sel_next;
      ramp_phase   <= phase_next;
      ramp_count   <= count_next;
      levels       <= levels_next;
      tick_divider <= div_next;
    end
  end

endmodule

// File: src/rgb_led_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// RGB LED pattern sequencer
// Button debounce and three colour ramp patterns, one tick per transfer.
// ----------------------------------------------------------------------------
// Path: an accepted input waits in the input register until the result register
// is free, and its result is then offered from the result register.
// Throughput: one tick per cycle while m_tready stays high; the tick path is a
// single pass of logic between the input register and the result register.
// Reset: synchronous; clears the pipeline, the press state and the pattern
// state, and loads the default debounce and short-press limits.
module rgb_led_pattern_sequencer
  import rlps_pkg::*;
#(
  parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // [0] button_pressed, rest zero
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // [7:0] red_level, [15:8] green_level,
                                            // [23:16] blue_level, [25:24] pattern_now,
                                            // [27:26] press_event, rest zero
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic              in_valid;
  logic              in_button;
  logic              advance;
  logic [HOLD_W-1:0] debounce_ticks;
  logic [HOLD_W-1:0] short_limit_ticks;
  logic [1:0]        press_event;
  lamp_t             lamp_next;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks    <= HOLD_W'(50);
      short_limit_ticks <= HOLD_W'(1000);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE:    debounce_ticks    <= cfg_data;
        REG_SHORT_LIMIT: short_limit_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_button <= s_tdata[0];
  end

  rlps_press_classifier u_classifier (
    .clk               (clk),
    .rst               (rst),
    .step              (advance),
    .pressed           (in_button),
    .debounce_ticks    (debounce_ticks),
    .short_limit_ticks (short_limit_ticks),
    .press_event       (press_event)
  );

  rlps_pattern_engine #(
    .LEVEL_MAX (LEVEL_MAX)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .press_event (press_event),
    .lamp_next   (lamp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'd0, press_event, lamp_next.pattern,
                  lamp_next.blue, lamp_next.green, lamp_next.red};
    end
  end

  a_pattern_code : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[25:24] != 2'd3)
    else $error("pattern code out of range");

  a_event_code : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[27:26] != 2'd3)
    else $error("press event code out of range");

  a_all_fade_equal : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[25:24] == PAT_ALL_FADE) |->
      (m_tdata[7:0] == m_tdata[15:8] && m_tdata[15:8] == m_tdata[23:16]))
    else $error("colours diverged in the all fade pattern");

  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !m_tvalid) |=> m_tvalid)
    else $error("pending tick did not reach the result register");

  a_empty_ready : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the result register is empty");

endmodule
